// ----- design/foch_pkg.sv -----
// ----------------------------------------------------------------------------
// foch_pkg
// Shared types and constants of the frame owner classifier and histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package foch_pkg;

  localparam int unsigned HIST_BINS    = 256;
  localparam int unsigned HIST_AW      = $clog2(HIST_BINS);
  localparam int unsigned PREFIX_SLOTS = 8;
  localparam int unsigned SLOT_W       = $clog2(PREFIX_SLOTS);
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned CFG_IDX_W    = 4;
  localparam int unsigned CFG_DATA_W   = 64;

  // Low seven bits of the device type byte; bit 7 is the pairing bit.
  localparam logic [7:0] DEV_TYPE_MASK = 8'h7F;

  localparam logic [15:0] RST_DEVICE_NUMBER  = 16'd14871;
  localparam logic [6:0]  RST_EXPECTED_TYPE  = 7'd11;
  localparam logic [7:0]  RST_EXPECTED_TRANS = 8'd5;
  localparam logic [63:0] RST_PREFIX_TABLE   = 64'h8877_1755_4433_2211;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEVICE_NUMBER  = 4'd0,
    CFG_EXPECTED_TYPE  = 4'd1,
    CFG_EXPECTED_TRANS = 4'd2,
    CFG_PREFIX_TABLE   = 4'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CLS_FOREIGN  = 3'd0,
    CLS_OWN_GOOD = 3'd1,
    CLS_OWN_BAD  = 3'd2,
    CLS_NOISE    = 3'd3,
    CLS_BIN_READ = 3'd4
  } frame_class_e;

  typedef struct packed {
    logic        mode;
    logic        crc_ok;
    logic [2:0]  match_slot;
    logic [7:0]  dev_id_hi;
    logic [7:0]  dev_type;
    logic [7:0]  tx_type;
    logic [7:0]  ctrl_byte;
    logic [31:0] time_addr;
    logic [7:0]  bin_index;
  } foch_in_t;

  typedef struct packed {
    logic [2:0]         frame_class;
    logic               odd_type;
    logic [15:0]        rebuilt_devnum;
    logic signed [31:0] delta_time;
    logic [31:0]        bin_count;
    logic [31:0]        count_own;
    logic [31:0]        count_foreign;
    logic [31:0]        count_bad_own;
    logic [31:0]        count_odd;
  } foch_out_t;

  // Histogram write port request.
  typedef struct packed {
    logic               en;
    logic [HIST_AW-1:0] addr;
    logic [CNT_W-1:0]   data;
  } hist_wr_t;

endpackage

`default_nettype wire

// ----- design/foch_hist_ram.sv -----
// ----------------------------------------------------------------------------
// foch_hist_ram
// Histogram bin memory with per-entry valid bits and write-to-read forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module foch_hist_ram (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     rd_en_i,
  input  wire logic [foch_pkg::HIST_AW-1:0] rd_addr_i,
  input  wire foch_pkg::hist_wr_t       wr_i,
  output logic [foch_pkg::CNT_W-1:0]    rd_data_o
);
  import foch_pkg::*;

  logic [CNT_W-1:0] mem [HIST_BINS];
  logic [HIST_BINS-1:0] vld_q;
  logic [CNT_W-1:0] rd_q;
  logic             rd_vld_q;
  logic             fwd_q;
  logic [CNT_W-1:0] fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // Valid bits stand in for the all-zero reset of the bins.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
        fwd_q    <= wr_i.en && (wr_i.addr == rd_addr_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_i.data;
    end
  end

  always_comb begin
    if (fwd_q) begin
      rd_data_o = fwd_data_q;
    end else if (rd_vld_q) begin
      rd_data_o = rd_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

`default_nettype wire

// ----- design/frame_owner_classifier_histogram_top.sv -----
// ----------------------------------------------------------------------------
// frame_owner_classifier_histogram_top
// Sorts received frames by owner, keeps frame counters and a histogram of the
// control byte of good own frames, and answers histogram bin reads.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in       in         in_valid_i / in_stall_o   foch_in_t  (frame or bin read)
//   out      out        out_valid_o / out_stall_i foch_out_t (one per input)
//   cfg      in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item is accepted per cycle unless the input stalls. An accepted item
// issues its histogram bin read as it is taken, is classified and written back
// in the classify stage, and its result then sits in the output register;
// the sustained rate is set by the single read-modify-write pass through the
// histogram memory. After reset every bin reads as zero at once, so there is
// no clearing pass. When the output register is full and stalled, an item in
// the classify stage holds there and the input stalls; otherwise a new
// transfer is taken every cycle.
`default_nettype none

module frame_owner_classifier_histogram_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire foch_pkg::foch_in_t                in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output foch_pkg::foch_out_t                    out_data_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [foch_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [foch_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import foch_pkg::*;

  // Configuration registers.
  logic [15:0] device_number_q;
  logic [6:0]  expected_type_q;
  logic [7:0]  expected_trans_q;
  logic [63:0] prefix_table_q;

  // Statistics state.
  logic [CNT_W-1:0] own_cnt_q, own_cnt_d;
  logic [CNT_W-1:0] foreign_cnt_q, foreign_cnt_d;
  logic [CNT_W-1:0] bad_own_cnt_q, bad_own_cnt_d;
  logic [CNT_W-1:0] odd_cnt_q, odd_cnt_d;
  logic [31:0]      last_time_q, last_time_d;
  logic             have_last_q, have_last_d;

  // Classify stage holding one item while its bin read returns.
  logic     s1_valid_q;
  foch_in_t s1_q;
  logic     s1_adv;
  logic     s1_fire;
  logic     in_accept;

  // Output register.
  logic      out_valid_q;
  foch_out_t out_q;
  foch_out_t res_d;

  logic [HIST_AW-1:0] rd_addr;
  logic [CNT_W-1:0]   hist_rd;
  hist_wr_t           hist_wr;

  frame_class_e cls;
  logic [7:0]   prefix_lo;
  logic [15:0]  devnum;
  logic         ours;
  logic         typical;
  logic         own_any;

  // The configuration port is always ready; it is to be written only while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_number_q  <= RST_DEVICE_NUMBER;
      expected_type_q  <= RST_EXPECTED_TYPE;
      expected_trans_q <= RST_EXPECTED_TRANS;
      prefix_table_q   <= RST_PREFIX_TABLE;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DEVICE_NUMBER:  device_number_q  <= cfg_data_i[15:0];
        CFG_EXPECTED_TYPE:  expected_type_q  <= cfg_data_i[6:0];
        CFG_EXPECTED_TRANS: expected_trans_q <= cfg_data_i[7:0];
        CFG_PREFIX_TABLE:   prefix_table_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The classify stage moves on whenever the output register is free or is
  // being emptied in this cycle.
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // A bin read looks at its own index; a frame looks at its control byte.
  assign rd_addr = in_data_i.mode ? in_data_i.bin_index : in_data_i.ctrl_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_data_i;
    end
  end

  // The write of the item leaving the classify stage is forwarded to a read
  // of the same bin issued in that cycle.
  foch_hist_ram u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (rd_addr),
    .wr_i      (hist_wr),
    .rd_data_o (hist_rd)
  );

  // Device number rebuild and type check.
  assign prefix_lo = prefix_table_q[{s1_q.match_slot, 3'b000} +: 8];
  assign devnum    = {s1_q.dev_id_hi, prefix_lo};
  assign ours      = (devnum == device_number_q);
  assign typical   = ((s1_q.dev_type & DEV_TYPE_MASK) == {1'b0, expected_type_q})
                     && (s1_q.tx_type == expected_trans_q);

  always_comb begin
    if (s1_q.mode) begin
      cls = CLS_BIN_READ;
    end else if (s1_q.crc_ok) begin
      cls = ours ? CLS_OWN_GOOD : CLS_FOREIGN;
    end else begin
      cls = ours ? CLS_OWN_BAD : CLS_NOISE;
    end
  end

  assign own_any = (cls == CLS_OWN_GOOD) || (cls == CLS_OWN_BAD);

  always_comb begin
    hist_wr.en   = s1_fire && (cls == CLS_OWN_GOOD);
    hist_wr.addr = s1_q.ctrl_byte;
    hist_wr.data = hist_rd + 32'd1;
  end

  // Next counter values and the result of the item in the classify stage.
  always_comb begin
    own_cnt_d     = own_cnt_q;
    foreign_cnt_d = foreign_cnt_q;
    bad_own_cnt_d = bad_own_cnt_q;
    odd_cnt_d     = odd_cnt_q;
    last_time_d   = last_time_q;
    have_last_d   = have_last_q;

    res_d                = '0;
    res_d.frame_class    = cls;

    case (cls)
      CLS_FOREIGN: begin
        foreign_cnt_d = foreign_cnt_q + 32'd1;
      end
      CLS_OWN_GOOD: begin
        own_cnt_d       = own_cnt_q + 32'd1;
        odd_cnt_d       = typical ? odd_cnt_q : odd_cnt_q + 32'd1;
        res_d.bin_count = hist_wr.data;
      end
      CLS_OWN_BAD: begin
        bad_own_cnt_d = bad_own_cnt_q + 32'd1;
      end
      CLS_BIN_READ: begin
        res_d.bin_count = hist_rd;
      end
      default: ;
    endcase

    if (!s1_q.mode) begin
      res_d.rebuilt_devnum = devnum;
    end

    if (own_any) begin
      res_d.odd_type   = !typical;
      res_d.delta_time = have_last_q ? $signed(s1_q.time_addr - last_time_q) : '0;
      last_time_d      = s1_q.time_addr;
      have_last_d      = 1'b1;
    end

    res_d.count_own     = own_cnt_d;
    res_d.count_foreign = foreign_cnt_d;
    res_d.count_bad_own = bad_own_cnt_d;
    res_d.count_odd     = odd_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_cnt_q     <= '0;
      foreign_cnt_q <= '0;
      bad_own_cnt_q <= '0;
      odd_cnt_q     <= '0;
      last_time_q   <= '0;
      have_last_q   <= 1'b0;
    end else if (s1_fire) begin
      own_cnt_q     <= own_cnt_d;
      foreign_cnt_q <= foreign_cnt_d;
      bad_own_cnt_q <= bad_own_cnt_d;
      odd_cnt_q     <= odd_cnt_d;
      last_time_q   <= last_time_d;
      have_last_q   <= have_last_d;
    end
  end

  // Output register: loaded as the classify stage advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An accepted transfer always occupies the classify stage next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted item did not reach the classify stage");

  // The histogram is only written by an item that leaves the classify stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_wr.en |-> (s1_valid_q && s1_adv && !s1_q.mode))
    else $error("histogram written without an advancing frame");

  // Counters change only when a result is produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> ($stable(own_cnt_q) && $stable(foreign_cnt_q)
                  && $stable(bad_own_cnt_q) && $stable(odd_cnt_q)))
    else $error("counter changed without a result");

  // A result waiting under stall keeps the classify stage from draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && s1_valid_q) |=> s1_valid_q)
    else $error("classify stage lost an item while the output stalled");

endmodule

`default_nettype wire

// ----- dv/frame_owner_classifier_histogram_top_tb.sv -----
// ----------------------------------------------------------------------------
// frame_owner_classifier_histogram_top_tb
// Drives frames and histogram bin reads into the classifier and keeps its own
// copy of the counters, the control-byte histogram and the registers. Each
// accepted transfer yields one expected report. Every report that comes out is
// compared field by field with the oldest expected one. Register writes happen
// only once the block has gone quiet.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_owner_classifier_histogram_top_tb;
  import foch_pkg::*;

  localparam int unsigned CLK_HALF       = 5;
  localparam int unsigned RESET_CYCLES   = 8;
  // The report of an item passes through the classify stage into the output
  // register, so this settling wait covers anything still in flight.
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_LIMIT    = 20000;
  localparam int unsigned TIMEOUT_CYCLES = 300000;
  localparam int unsigned HOLD_CYCLES    = 40;
  localparam int unsigned PHASE_ITEMS    = 180;
  localparam int unsigned BURST_ITEMS    = 24;
  // A few control byte values get most of the traffic, so that their bins
  // climb well past one.
  localparam int unsigned HOT_BINS       = 4;
  // With the reset prefix table, slot 5 holds the low byte of the reset
  // device number.
  localparam logic [2:0]  RST_OWN_SLOT   = 3'd5;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  foch_in_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  foch_out_t             out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Our copy of the registers.
  logic [15:0] watch_devnum;
  logic [6:0]  want_type;
  logic [7:0]  want_trans;
  logic [63:0] slot_prefixes;

  // Our copy of the statistics.
  logic [31:0] bin_tally [HIST_BINS];
  logic [31:0] tally_own;
  logic [31:0] tally_foreign;
  logic [31:0] tally_bad_own;
  logic [31:0] tally_odd;
  logic [31:0] prev_own_stamp;
  logic        seen_own;

  // Reports owed by the block, oldest first.
  foch_out_t   expected_reports [$];

  int unsigned mismatch_cnt = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // A long receiver hold is requested by bumping hold_req; the receiver
  // process notices the change and counts the hold down on its own.
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  // Running microsecond clock for the random frames; it wraps like the
  // timestamp on air.
  logic [31:0] air_clock;

  frame_owner_classifier_histogram_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Works out the report of one accepted item and moves our statistics on.
  function automatic foch_out_t predict_report(foch_in_t it);
    foch_out_t   rep;
    logic [15:0] devnum;
    logic        ours;
    logic        typical;
    rep = '0;
    if (it.mode) begin
      // A bin read looks at the histogram and touches nothing else.
      rep.frame_class = CLS_BIN_READ;
      rep.bin_count   = bin_tally[it.bin_index];
    end else begin
      devnum  = {it.dev_id_hi, slot_prefixes[it.match_slot*8 +: 8]};
      ours    = (devnum == watch_devnum);
      typical = ((it.dev_type & DEV_TYPE_MASK) == {1'b0, want_type}) &&
                (it.tx_type == want_trans);
      rep.rebuilt_devnum = devnum;
      if (it.crc_ok && !ours) begin
        rep.frame_class = CLS_FOREIGN;
        tally_foreign++;
      end else if (it.crc_ok) begin
        rep.frame_class = CLS_OWN_GOOD;
        tally_own++;
        bin_tally[it.ctrl_byte] = bin_tally[it.ctrl_byte] + 32'd1;
        rep.bin_count = bin_tally[it.ctrl_byte];
        if (!typical) tally_odd++;
      end else if (!ours) begin
        rep.frame_class = CLS_NOISE;
      end else begin
        // Odd type bytes on a bad frame show up in the report only.
        rep.frame_class = CLS_OWN_BAD;
        tally_bad_own++;
      end
      if (ours) begin
        rep.odd_type   = !typical;
        rep.delta_time = seen_own ? it.time_addr - prev_own_stamp : '0;
        prev_own_stamp = it.time_addr;
        seen_own       = 1'b1;
      end
    end
    rep.count_own     = tally_own;
    rep.count_foreign = tally_foreign;
    rep.count_bad_own = tally_bad_own;
    rep.count_odd     = tally_odd;
    return rep;
  endfunction

  function automatic foch_in_t frame_item(logic crc, logic [2:0] slot, logic [7:0] hi,
                                          logic [7:0] dty, logic [7:0] tty,
                                          logic [7:0] ctrl, logic [31:0] stamp);
    foch_in_t it;
    it.mode       = 1'b0;
    it.crc_ok     = crc;
    it.match_slot = slot;
    it.dev_id_hi  = hi;
    it.dev_type   = dty;
    it.tx_type    = tty;
    it.ctrl_byte  = ctrl;
    it.time_addr  = stamp;
    it.bin_index  = 8'($urandom);
    return it;
  endfunction

  // The frame fields of a bin read are junk; the block must ignore them.
  function automatic foch_in_t bin_read_item(logic [7:0] bin);
    foch_in_t it;
    it = frame_item(1'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), $urandom);
    it.mode      = 1'b1;
    it.bin_index = bin;
    return it;
  endfunction

  // Mostly frames of the watched device with random content, then near misses
  // on the device number, bin reads and plain noise.
  function automatic foch_in_t random_item();
    foch_in_t    it;
    int unsigned pick;
    int unsigned hits [$];
    logic [7:0]  ctrl;
    logic [31:0] stamp;
    pick = $urandom_range(99);
    for (int s = 0; s < PREFIX_SLOTS; s++) begin
      if (slot_prefixes[s*8 +: 8] == watch_devnum[7:0]) hits.push_back(s);
    end
    ctrl = ($urandom_range(1) == 0) ? 8'($urandom_range(HOT_BINS - 1)) : 8'($urandom);
    if ($urandom_range(19) == 0) begin
      stamp = $urandom;
    end else begin
      air_clock = air_clock + 32'($urandom_range(20000, 1));
      stamp     = air_clock;
    end
    it = frame_item(1'($urandom_range(99) < 85), 3'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), ctrl, stamp);
    if (pick < 10) begin
      it.mode      = 1'b1;
      it.bin_index = ($urandom_range(1) == 0) ? 8'($urandom_range(HOT_BINS - 1))
                                              : 8'($urandom);
    end else if (pick < 80 && hits.size() != 0) begin
      it.match_slot = 3'(hits[$urandom_range(hits.size() - 1)]);
      it.dev_id_hi  = watch_devnum[15:8];
      if (pick >= 65) begin
        // One flipped bit in the high byte turns it into someone else's frame.
        it.dev_id_hi = it.dev_id_hi ^ 8'(1 << $urandom_range(7));
      end else if ($urandom_range(4) != 0) begin
        it.dev_type = {1'($urandom), want_type};
        it.tx_type  = want_trans;
      end
    end
    return it;
  endfunction

  // Offers one item after the current idle pattern and waits for its transfer.
  // Valid stays up afterwards; the next call or a drain changes it at the
  // following falling edge.
  task automatic send_item(input foch_in_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    do @(posedge clk_i); while (in_stall_o);
    expected_reports.push_back(predict_report(it));
  endtask

  // Stops offering and waits until every report is back and the pipeline has
  // had time to empty.
  task automatic wait_for_drain();
    int unsigned waited;
    waited = 0;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes a register; only called while the block is quiet. Data bits above
  // a register's width are dropped, and an index past the map is ignored.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_DEVICE_NUMBER:  watch_devnum  = value[15:0];
      CFG_EXPECTED_TYPE:  want_type     = value[6:0];
      CFG_EXPECTED_TRANS: want_trans    = value[7:0];
      CFG_PREFIX_TABLE:   slot_prefixes = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      mismatch_cnt++;
    end
  endtask

  // Directed frames under the reset settings: field extremes, every class,
  // timestamp wrap and a step back in time, odd type bytes on good and bad
  // frames, and bin reads before and after the histogram moves.
  task automatic test_directed_cases();
    foch_in_t   ones;
    logic [7:0] hi;
    logic [7:0] typ;
    hi = RST_DEVICE_NUMBER[15:8];
    typ = {1'b1, RST_EXPECTED_TYPE};
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_item(bin_read_item(8'h00));
    send_item(bin_read_item(8'hFF));
    // First own frame: there is no earlier stamp, so the spacing is zero.
    send_item(frame_item(1'b1, RST_OWN_SLOT, hi, typ, RST_EXPECTED_TRANS, 8'h00,
                         32'h0000_0000));
    send_item(frame_item(1'b1, RST_OWN_SLOT, hi, {1'b0, RST_EXPECTED_TYPE},
                         RST_EXPECTED_TRANS, 8'hFF, 32'hFFFF_FFF0));
    // The timestamp wraps, so the spacing is small and positive.
    send_item(frame_item(1'b1, RST_OWN_SLOT, hi, typ, RST_EXPECTED_TRANS, 8'hFF,
                         32'h0000_0010));
    send_item(frame_item(1'b1, RST_OWN_SLOT, hi, {1'b1, ~RST_EXPECTED_TYPE},
                         RST_EXPECTED_TRANS, 8'h80, 32'h0000_0100));
    send_item(frame_item(1'b1, RST_OWN_SLOT, hi, typ, ~RST_EXPECTED_TRANS, 8'h80,
                         32'h0000_0200));
    send_item(frame_item(1'b0, RST_OWN_SLOT, hi, typ, RST_EXPECTED_TRANS, 8'h55,
                         32'h7FFF_FFFF));
    send_item(frame_item(1'b0, RST_OWN_SLOT, hi, 8'h00, ~RST_EXPECTED_TRANS, 8'h55,
                         32'hFFFF_FFFF));
    // Going back in time gives a negative spacing.
    send_item(frame_item(1'b1, RST_OWN_SLOT, hi, typ, RST_EXPECTED_TRANS, 8'h01,
                         32'h8000_0000));
    send_item(frame_item(1'b1, 3'd0, hi, typ, RST_EXPECTED_TRANS, 8'h02, 32'h8000_0010));
    send_item(frame_item(1'b1, RST_OWN_SLOT, hi ^ 8'h80, typ, RST_EXPECTED_TRANS, 8'h02,
                         32'h8000_0020));
    send_item(frame_item(1'b0, 3'd0, hi, typ, RST_EXPECTED_TRANS, 8'h02, 32'h8000_0030));
    ones = '1;
    ones.mode   = 1'b0;
    ones.crc_ok = 1'b0;
    send_item(ones);
    ones.crc_ok = 1'b1;
    send_item(ones);
    ones.mode = 1'b1;
    send_item(ones);
    send_item('0);
    send_item(bin_read_item(8'h00));
    send_item(bin_read_item(8'h80));
  endtask

  // Both ends of every register, junk in the unused data bits, and a write to
  // an index past the register map.
  task automatic test_register_extremes();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    wait_for_drain();
    write_register(CFG_DEVICE_NUMBER, 64'hA5A5_A5A5_A5A5_FFFF);
    write_register(CFG_EXPECTED_TYPE, 64'hFFFF_FFFF_FFFF_FF7F);
    write_register(CFG_EXPECTED_TRANS, 64'h5A5A_5A5A_5A5A_5AFF);
    write_register(CFG_PREFIX_TABLE, '1);
    send_item(frame_item(1'b1, 3'($urandom), 8'hFF, 8'h7F, 8'hFF, 8'hFE, 32'h1234_5678));
    send_item(frame_item(1'b0, 3'($urandom), 8'hFF, 8'hFF, 8'hFF, 8'hFE, 32'h1234_5679));
    repeat (8) send_item(random_item());
    wait_for_drain();
    write_register(CFG_DEVICE_NUMBER, 64'hFFFF_FFFF_FFFF_0000);
    write_register(CFG_EXPECTED_TYPE, 64'hFFFF_FFFF_FFFF_FF80);
    write_register(CFG_EXPECTED_TRANS, 64'hFFFF_FFFF_FFFF_FF00);
    write_register(CFG_PREFIX_TABLE, '0);
    send_item(frame_item(1'b1, 3'($urandom), 8'h00, 8'h80, 8'h00, 8'hFE, 32'h2000_0000));
    send_item(frame_item(1'b1, 3'($urandom), 8'h00, 8'h7F, 8'h00, 8'hFE, 32'h2000_0001));
    send_item(bin_read_item(8'hFE));
    wait_for_drain();
    write_register(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, int'(CFG_PREFIX_TABLE) + 1)),
                   {$urandom, $urandom});
    send_item(frame_item(1'b1, 3'($urandom), 8'h00, 8'h80, 8'h00, 8'hFE, 32'h2000_0002));
    repeat (8) send_item(random_item());
  endtask

  // Random traffic under fresh random settings in each idling phase. The
  // device number is always built from one of the prefix bytes, so that own
  // frames can occur.
  task automatic test_random_traffic();
    logic [63:0] table_bits;
    logic [2:0]  own_slot;
    for (int ph = 0; ph < 4; ph++) begin
      wait_for_drain();
      table_bits = {$urandom, $urandom};
      own_slot   = 3'($urandom);
      write_register(CFG_PREFIX_TABLE, table_bits);
      write_register(CFG_DEVICE_NUMBER,
                     {48'($urandom), 8'($urandom), table_bits[own_slot*8 +: 8]});
      write_register(CFG_EXPECTED_TYPE, {$urandom, $urandom});
      write_register(CFG_EXPECTED_TRANS, {$urandom, $urandom});
      case (ph)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 62;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 62;
        end
        default: begin
          sender_idle_pct = 7;
          recv_stall_pct  = 7;
        end
      endcase
      repeat (PHASE_ITEMS) send_item(random_item());
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // pipeline fills and the input stalls. Then the sender waits for every
  // report before a last burst.
  task automatic test_backpressure();
    wait_for_drain();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_req++;
    repeat (BURST_ITEMS) send_item(random_item());
    wait_for_drain();
    sender_idle_pct = 30;
    recv_stall_pct  = 30;
    repeat (BURST_ITEMS) send_item(random_item());
  endtask

  // Receiver: a requested hold wins over the random stall pattern.
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Every report transfer is matched against the oldest outstanding report.
  always @(posedge clk_i) begin
    foch_out_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_reports.size() == 0) begin
        $error("report transfer with no item outstanding");
        mismatch_cnt++;
      end else begin
        want = expected_reports.pop_front();
        compare_field("frame_class", 32'(want.frame_class), 32'(out_data_o.frame_class));
        compare_field("odd_type", 32'(want.odd_type), 32'(out_data_o.odd_type));
        compare_field("rebuilt_devnum", 32'(want.rebuilt_devnum),
                      32'(out_data_o.rebuilt_devnum));
        compare_field("delta_time", want.delta_time, out_data_o.delta_time);
        compare_field("bin_count", want.bin_count, out_data_o.bin_count);
        compare_field("count_own", want.count_own, out_data_o.count_own);
        compare_field("count_foreign", want.count_foreign, out_data_o.count_foreign);
        compare_field("count_bad_own", want.count_bad_own, out_data_o.count_bad_own);
        compare_field("count_odd", want.count_odd, out_data_o.count_odd);
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;

    watch_devnum  = RST_DEVICE_NUMBER;
    want_type     = RST_EXPECTED_TYPE;
    want_trans    = RST_EXPECTED_TRANS;
    slot_prefixes = RST_PREFIX_TABLE;
    foreach (bin_tally[i]) bin_tally[i] = '0;
    tally_own      = '0;
    tally_foreign  = '0;
    tally_bad_own  = '0;
    tally_odd      = '0;
    prev_own_stamp = '0;
    seen_own       = 1'b0;
    air_clock      = $urandom;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();

    recv_stall_pct = 0;
    wait_for_drain();
    if (expected_reports.size() != 0) begin
      $error("%0d reports never came out", expected_reports.size());
      mismatch_cnt += expected_reports.size();
    end
    if (mismatch_cnt == 0) begin
      $display("frame_owner_classifier_histogram_top_tb: done, clean");
    end else begin
      $display("frame_owner_classifier_histogram_top_tb: done, errors");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("frame_owner_classifier_histogram_top_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
